>>> design/cts_pkg.sv
// Shared types and constants for the chip thermal frequency stepper.
// No dependencies; cts_eval and the top level import this package.
`timescale 1ns / 1ps

package cts_pkg;

	localparam int CHIP_W      = 4;
	localparam int TEMP_W      = 11;
	localparam int FREQ_W      = 22;
	localparam int STEP_W      = 4;
	localparam int MASK_W      = 4;
	localparam int FIELD_CORES = 4;
	// Four 11-bit temperatures, or an 11-bit limit times four, fit in 13 bits.
	localparam int SUM_W       = 13;
	localparam int CHIP_CODES  = 2 ** CHIP_W;

	localparam logic [TEMP_W-1:0] TEMP_LIMIT_RESET = 11'd784;

	typedef enum logic [1:0] {
		DIR_HOLD   = 2'd0,
		DIR_FASTER = 2'd1,
		DIR_SLOWER = 2'd2
	} dir_t;

	// Step 0 is the fastest entry; entries past the eleventh repeat the slowest.
	localparam logic [FREQ_W-1:0] FREQ_TABLE [16] = '{
		22'd2395000, 22'd2394000, 22'd2261000, 22'd2128000,
		22'd1995000, 22'd1862000, 22'd1729000, 22'd1596000,
		22'd1463000, 22'd1330000, 22'd1197000, 22'd1197000,
		22'd1197000, 22'd1197000, 22'd1197000, 22'd1197000
	};

	typedef struct packed {
		logic [CHIP_W-1:0] chip_index;
		logic [TEMP_W-1:0] temp_core0;
		logic [TEMP_W-1:0] temp_core1;
		logic [TEMP_W-1:0] temp_core2;
		logic [TEMP_W-1:0] temp_core3;
		logic [FREQ_W-1:0] cur_freq_core0;
		logic [FREQ_W-1:0] cur_freq_core1;
		logic [FREQ_W-1:0] cur_freq_core2;
		logic [FREQ_W-1:0] cur_freq_core3;
	} in_item_t;

	typedef struct packed {
		logic [CHIP_W-1:0] chip_out;
		logic [FREQ_W-1:0] new_freq_khz;
		logic [STEP_W-1:0] new_step;
		logic [1:0]        direction;
		logic              hot_at_min;
		logic [MASK_W-1:0] change_mask;
	} result_t;

endpackage

>>> design/cts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-chip step store; no package dependency.
`timescale 1ns / 1ps

module cts_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/cts_eval.sv
// Combinational evaluation of one item: temperature sum against the limit,
// step update, table frequency and per-core change mask. Uses cts_pkg.
`timescale 1ns / 1ps

module cts_eval #(
	parameter int CORES_PER_CHIP = 4,
	parameter int NUM_LEVELS     = 11
) (
	input  cts_pkg::in_item_t            item,
	input  logic [cts_pkg::TEMP_W-1:0]   temp_limit,
	input  logic [cts_pkg::STEP_W-1:0]   cur_step,
	output cts_pkg::result_t             result
);

	import cts_pkg::*;

	localparam int USED_CORES = CORES_PER_CHIP < FIELD_CORES ? CORES_PER_CHIP : FIELD_CORES;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_LEVELS - 1);

	logic [TEMP_W-1:0] temps [FIELD_CORES];
	logic [FREQ_W-1:0] freqs [FIELD_CORES];
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  limit_x;
	logic              hot;
	logic [STEP_W-1:0] next_step;
	dir_t              dir;
	logic              hot_min;
	logic [FREQ_W-1:0] freq;
	logic [MASK_W-1:0] mask;

	assign temps[0] = item.temp_core0;
	assign temps[1] = item.temp_core1;
	assign temps[2] = item.temp_core2;
	assign temps[3] = item.temp_core3;
	assign freqs[0] = item.cur_freq_core0;
	assign freqs[1] = item.cur_freq_core1;
	assign freqs[2] = item.cur_freq_core2;
	assign freqs[3] = item.cur_freq_core3;

	always_comb begin
		sum = '0;
		for (int j = 0; j < USED_CORES; j++) begin
			sum = sum + SUM_W'(temps[j]);
		end
	end

	// Comparing the sum against limit times core count avoids a divider.
	assign limit_x = SUM_W'(temp_limit) * SUM_W'(USED_CORES);
	assign hot = sum > limit_x;

	always_comb begin
		next_step = cur_step;
		dir = DIR_HOLD;
		hot_min = 1'b0;
		if (hot) begin
			if (cur_step >= LAST_STEP) begin
				next_step = LAST_STEP;
				hot_min = 1'b1;
			end else begin
				next_step = cur_step + STEP_W'(1);
				dir = DIR_SLOWER;
			end
		end else if (cur_step != '0) begin
			next_step = cur_step - STEP_W'(1);
			dir = DIR_FASTER;
		end
	end

	assign freq = FREQ_TABLE[next_step];

	always_comb begin
		mask = '0;
		for (int j = 0; j < FIELD_CORES; j++) begin
			mask[j] = (j < USED_CORES) && (freqs[j] != freq);
		end
	end

	always_comb begin
		result.chip_out     = item.chip_index;
		result.new_freq_khz = freq;
		result.new_step     = next_step;
		result.direction    = dir;
		result.hot_at_min   = hot_min;
		result.change_mask  = mask;
	end

endmodule

>>> design/chip_thermal_frequency_stepper.sv
// Chip thermal frequency stepper, top level. Uses cts_pkg, cts_ram, cts_eval.
// An accepted item passes the s1 registers, then the s2 registers, which strobe done.
// Throughput: one item per cycle; busy is always low. The step store read is
// issued at acceptance and an item to the same chip as the one ahead of it
// takes that item's new step by forwarding. The receiver cannot stall.
// Reset clears every chip's step to the fastest entry and restores temp_limit.
`timescale 1ns / 1ps

module chip_thermal_frequency_stepper #(
	parameter int NUM_CHIPS      = 16,
	parameter int CORES_PER_CHIP = 4,
	parameter int NUM_LEVELS     = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cts_pkg::in_item_t            item,
	input  logic                         cfg_we,
	input  logic [cts_pkg::TEMP_W-1:0]   cfg_data,
	output logic                         done,
	output cts_pkg::result_t             result
);

	import cts_pkg::*;

	localparam int SLOT_W = NUM_CHIPS > 1 ? $clog2(NUM_CHIPS) : 1;

	logic [SLOT_W-1:0] slot_lut [CHIP_CODES];
	logic [SLOT_W-1:0] slot_in;
	logic [TEMP_W-1:0] temp_limit_q;
	logic [NUM_CHIPS-1:0] valid_q;

	logic              start_s1;
	in_item_t          item_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [STEP_W-1:0] ram_rdata;
	logic [STEP_W-1:0] cur_step;
	result_t           eval_result;

	logic              done_s2;
	result_t           result_s2;
	logic [SLOT_W-1:0] slot_s2;

	// Chip index to store slot, with indices past the chip count wrapping.
	for (genvar g = 0; g < CHIP_CODES; g++) begin : g_slot
		assign slot_lut[g] = SLOT_W'(g % NUM_CHIPS);
	end

	assign slot_in = slot_lut[item.chip_index];
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_limit_q <= TEMP_LIMIT_RESET;
		end else if (cfg_we) begin
			temp_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			start_s1 <= start;
			done_s2 <= start_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		slot_s1 <= slot_in;
		result_s2 <= eval_result;
		slot_s2 <= slot_s1;
	end

	cts_ram #(
		.WIDTH(STEP_W),
		.DEPTH(NUM_CHIPS)
	) u_step_ram (
		.clk  (clk),
		.we   (start_s1),
		.waddr(slot_s1),
		.wdata(eval_result.new_step),
		.raddr(slot_in),
		.rdata(ram_rdata)
	);

	// A chip never written since reset is at the fastest step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (start_s1) begin
			valid_q[slot_s1] <= 1'b1;
		end
	end

	// The RAM read for this item was taken while the item ahead was still writing.
	always_comb begin
		if (done_s2 && slot_s2 == slot_s1) begin
			cur_step = result_s2.new_step;
		end else if (valid_q[slot_s1]) begin
			cur_step = ram_rdata;
		end else begin
			cur_step = '0;
		end
	end

	cts_eval #(
		.CORES_PER_CHIP(CORES_PER_CHIP),
		.NUM_LEVELS    (NUM_LEVELS)
	) u_eval (
		.item      (item_s1),
		.temp_limit(temp_limit_q),
		.cur_step  (cur_step),
		.result    (eval_result)
	);

	assign done = done_s2;
	assign result = result_s2;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item did not produce a result two cycles later");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.new_step <= STEP_W'(NUM_LEVELS - 1))
		else $error("new step beyond the slowest level");

	a_hot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hot_at_min) |->
		(result.new_step == STEP_W'(NUM_LEVELS - 1) && result.direction == DIR_HOLD))
		else $error("hot flag raised without holding at the slowest step");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##2 !done)
		else $error("result strobe without an accepted item");
`endif

endmodule

>>> tb/tb_chip_thermal_frequency_stepper.sv
// Self-checking testbench for chip_thermal_frequency_stepper: directed corner items,
// then random phases under several temp_limit settings, checked by a scoreboard.
// Depends on cts_pkg and the chip_thermal_frequency_stepper RTL.
`timescale 1ns / 1ps

module tb_chip_thermal_frequency_stepper;
	import cts_pkg::*;

	localparam int N_CHIPS    = 16;
	localparam int N_CORES    = 4;
	localparam int N_STEPS    = 11;
	localparam int SLOWEST    = N_STEPS - 1;
	localparam int CLK_HALF   = 4;
	localparam int DRAIN_WAIT = 4;

	localparam logic [FREQ_W-1:0] STEP_FREQ_KHZ [16] = '{
		22'd2395000, 22'd2394000, 22'd2261000, 22'd2128000,
		22'd1995000, 22'd1862000, 22'd1729000, 22'd1596000,
		22'd1463000, 22'd1330000, 22'd1197000, 22'd1197000,
		22'd1197000, 22'd1197000, 22'd1197000, 22'd1197000
	};

	// Tracks each chip's step and the limit, and queues the result each item must produce.
	class thermal_step_scoreboard;
		logic [STEP_W-1:0] step_of_chip [N_CHIPS];
		logic [TEMP_W-1:0] temp_limit_q;
		result_t           expected_results [$];
		int                errors;

		function new();
			foreach (step_of_chip[c])
				step_of_chip[c] = '0;
			temp_limit_q = TEMP_LIMIT_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [TEMP_W-1:0] v);
			temp_limit_q = v;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		function void note_item(in_item_t it);
			result_t           r;
			int unsigned       sum;
			int unsigned       slot;
			int                stp;
			logic [FREQ_W-1:0] cur [N_CORES];
			cur = '{it.cur_freq_core0, it.cur_freq_core1, it.cur_freq_core2,
				it.cur_freq_core3};
			slot = it.chip_index % N_CHIPS;
			stp = int'(step_of_chip[slot]);
			sum = int'(it.temp_core0) + int'(it.temp_core1) + int'(it.temp_core2)
				+ int'(it.temp_core3);
			r = '0;
			r.chip_out = it.chip_index;
			r.direction = DIR_HOLD;
			if (sum > int'(temp_limit_q) * N_CORES) begin
				if (stp >= SLOWEST) begin
					stp = SLOWEST;
					r.hot_at_min = 1'b1;
				end else begin
					stp++;
					r.direction = DIR_SLOWER;
				end
			end else if (stp > 0) begin
				stp--;
				r.direction = DIR_FASTER;
			end
			step_of_chip[slot] = stp[STEP_W-1:0];
			r.new_step = stp[STEP_W-1:0];
			r.new_freq_khz = STEP_FREQ_KHZ[stp];
			for (int j = 0; j < N_CORES; j++)
				r.change_mask[j] = (cur[j] != r.new_freq_khz);
			expected_results.push_back(r);
		endfunction

		task check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result for chip %0d with none expected",
					got.chip_out));
				return;
			end
			want = expected_results.pop_front();
			if (got.chip_out !== want.chip_out)
				report_mismatch($sformatf("chip_out %0d, want %0d", got.chip_out,
					want.chip_out));
			if (got.new_freq_khz !== want.new_freq_khz)
				report_mismatch($sformatf("chip %0d new_freq_khz %0d, want %0d",
					want.chip_out, got.new_freq_khz, want.new_freq_khz));
			if (got.new_step !== want.new_step)
				report_mismatch($sformatf("chip %0d new_step %0d, want %0d",
					want.chip_out, got.new_step, want.new_step));
			if (got.direction !== want.direction)
				report_mismatch($sformatf("chip %0d direction %0d, want %0d",
					want.chip_out, got.direction, want.direction));
			if (got.hot_at_min !== want.hot_at_min)
				report_mismatch($sformatf("chip %0d hot_at_min %b, want %b",
					want.chip_out, got.hot_at_min, want.hot_at_min));
			if (got.change_mask !== want.change_mask)
				report_mismatch($sformatf("chip %0d change_mask %b, want %b",
					want.chip_out, got.change_mask, want.change_mask));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_item_t            item;
	logic                cfg_we;
	logic [TEMP_W-1:0]   cfg_data;
	logic                done;
	result_t             result;

	thermal_step_scoreboard sb;
	bit                     no_gaps;

	chip_thermal_frequency_stepper #(
		.NUM_CHIPS(N_CHIPS),
		.CORES_PER_CHIP(N_CORES),
		.NUM_LEVELS(N_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Inputs are stable at the rising edge, so the sampled values are the accepted ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_limit(cfg_data);
			if (start && !busy)
				sb.note_item(item);
			if (done)
				sb.check_result(result);
		end
	end

	function automatic bit take_gap();
		return !no_gaps && ($urandom_range(0, 99) < 18);
	endfunction

	function automatic in_item_t make_item(int chip, int t0, int t1, int t2, int t3,
		int f0, int f1, int f2, int f3);
		in_item_t it;
		it.chip_index = CHIP_W'(chip);
		it.temp_core0 = TEMP_W'(t0);
		it.temp_core1 = TEMP_W'(t1);
		it.temp_core2 = TEMP_W'(t2);
		it.temp_core3 = TEMP_W'(t3);
		it.cur_freq_core0 = FREQ_W'(f0);
		it.cur_freq_core1 = FREQ_W'(f1);
		it.cur_freq_core2 = FREQ_W'(f2);
		it.cur_freq_core3 = FREQ_W'(f3);
		return it;
	endfunction

	function automatic int temp_near(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return v;
	endfunction

	function automatic int pick_temp(int mode, int lim);
		case (mode)
			0: return temp_near(lim, 3);
			1: return $urandom_range(lim, 2047);
			2: return $urandom_range(0, lim);
			default: return $urandom_range(0, 2047);
		endcase
	endfunction

	function automatic int pick_freq();
		if ($urandom_range(0, 1))
			return int'(STEP_FREQ_KHZ[$urandom_range(0, SLOWEST)]);
		return $urandom_range(0, 'h3FFFFF);
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		while (take_gap()) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Stop sending and let every outstanding result come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_limit(logic [TEMP_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int count, int lim);
		int mode;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			mode = (r < 55) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : 3;
			// Mostly a few chips so that items to the same chip often come back to back.
			send_item(make_item(
				($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 15),
				pick_temp(mode, lim), pick_temp(mode, lim),
				pick_temp(mode, lim), pick_temp(mode, lim),
				pick_freq(), pick_freq(), pick_freq(), pick_freq()));
			if (n == count / 2 && $urandom_range(0, 1))
				drain();
		end
	endtask

	initial begin
		int lim;
		sb = new();
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Cool chip already at the fastest step, with frequency fields at both extremes.
		send_item(make_item(0, 0, 0, 0, 0, 2395000, 0, 'h3FFFFF, 2395000));
		// Drive one chip all the way to the slowest step, then past it.
		for (int k = 0; k < 12; k++)
			send_item(make_item(1, 2047, 2047, 2047, 2047,
				int'(STEP_FREQ_KHZ[(k + 1 > SLOWEST) ? SLOWEST : k + 1]), 'h3FFFFF,
				0, int'(STEP_FREQ_KHZ[SLOWEST])));
		send_item(make_item(1, 0, 0, 0, 0, int'(STEP_FREQ_KHZ[9]), 1, 2, 3));
		// Sum exactly at the limit times the core count is not hot; one above is.
		send_item(make_item(2, 784, 784, 784, 785, 2394000, 0, 0, 0));
		send_item(make_item(2, 784, 784, 784, 784, 2395000, 2395000, 2395000, 2395000));
		send_item(make_item(2, 0, 0, 0, 2047, 0, 0, 0, 0));
		send_item(make_item(15, 2047, 0, 2047, 0, 'h3FFFFF, 'h3FFFFF, 'h3FFFFF,
			'h3FFFFF));
		send_item(make_item(15, 1, 2, 4, 8, 2394000, 2395000, 0, 'h2AAAAA));
		send_item(make_item(7, 1024, 512, 256, 128, 'h155555, 'h2AAAAA, 0, 0));

		// Long stretch with the sender never pausing.
		no_gaps = 1'b1;
		random_phase(100, 784);
		no_gaps = 1'b0;

		write_limit(11'd0);
		send_item(make_item(3, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_item(3, 0, 0, 0, 1, 0, 0, 0, 0));
		random_phase(80, 0);

		write_limit(11'd2047);
		send_item(make_item(4, 2047, 2047, 2047, 2047, 0, 0, 0, 0));
		random_phase(80, 2047);

		for (int p = 0; p < 2; p++) begin
			lim = $urandom_range(0, 2047);
			write_limit(TEMP_W'(lim));
			random_phase(80, lim);
		end

		write_limit(TEMP_LIMIT_RESET);
		random_phase(60, int'(TEMP_LIMIT_RESET));

		drain();
		repeat (6) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/cts_pkg.sv
design/cts_ram.sv
design/cts_eval.sv
design/chip_thermal_frequency_stepper.sv
tb/tb_chip_thermal_frequency_stepper.sv
